FILE: design/i2c_bit_level_master_assert.svh
// Assertion macros used by the I2C bit-level master top-level design file.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// Checked only outside reset.
`define I2CBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define I2CBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/i2cbm_pkg.sv
// Types, codes and helpers for the I2C bit-level master.
package i2cbm_pkg;

  typedef enum logic [2:0] {
    FUNC_NONE  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_STOP  = 3'd2,
    FUNC_SEND  = 3'd3,
    FUNC_READ  = 3'd4,
    FUNC_WAIT  = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_TX_SET  = 4'd5,
    PH_TX_HI   = 4'd6,
    PH_TX_LO   = 4'd7,
    PH_RX_LO   = 4'd8,
    PH_RX_HI   = 4'd9,
    PH_AK_LO   = 4'd10,
    PH_AK_HI   = 4'd11,
    PH_WA_LO   = 4'd12,
    PH_WA_HI   = 4'd13,
    PH_WA_POLL = 4'd14
  } phase_t;

  localparam logic [1:0] CFG_START_STOP_TICKS = 2'd0;
  localparam logic [1:0] CFG_BIT_HALF_TICKS   = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT      = 2'd2;

  localparam logic [7:0]  START_STOP_TICKS_RESET = 8'd4;
  localparam logic [7:0]  BIT_HALF_TICKS_RESET   = 8'd2;
  localparam logic [15:0] ACK_TIMEOUT_RESET      = 16'd250;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [15:0] ack_timeout;
    logic [7:0]  bit_half_ticks;
    logic [7:0]  start_stop_ticks;
  } timing_t;

  typedef struct packed {
    logic       ack_failed;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_out;
    logic       scl_out;
  } result_t;

  // A tick count of zero behaves as one.
  function automatic logic [7:0] span(input logic [7:0] ticks);
    span = (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
  endfunction

endpackage

FILE: design/i2c_bit_level_master.sv
// The result of an accepted item is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; each tick updates the bus sequencer in a single pass.
// The input stalls only while the output register holds a result that is not taken.
// Reset (synchronous, active high) returns the bus to SCL and SDA high and driven,
// the sequencer to idle and the timing registers to their default values.
`include "i2c_bit_level_master_assert.svh"

// Top level of the I2C bit-level master: stream handshake, timing registers, result register.
module i2c_bit_level_master import i2cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tx_byte, send_ack, sda_in, zero fill
  input  logic [2:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_out, sda_out, sda_drive, busy_res, done_res,
                                 // rx_byte, ack_failed, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  timing_t timing;
  result_t result;
  logic    step;

  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.start_stop_ticks <= START_STOP_TICKS_RESET;
      timing.bit_half_ticks   <= BIT_HALF_TICKS_RESET;
      timing.ack_timeout      <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_STOP_TICKS: timing.start_stop_ticks <= cfg_data[7:0];
        CFG_BIT_HALF_TICKS:   timing.bit_half_ticks   <= cfg_data[7:0];
        CFG_ACK_TIMEOUT:      timing.ack_timeout      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  i2cbm_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .func     (s_tuser),
    .tx_byte  (s_tdata[7:0]),
    .send_ack (s_tdata[8]),
    .sda_in   (s_tdata[9]),
    .timing   (timing),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {2'b00, result};
    end
  end

  `I2CBM_ASSERT(a_accept_fills, (s_tvalid && s_tready) |=> m_tvalid, "accepted item gave no result")
  `I2CBM_ASSERT_ALWAYS(a_stall_full, !s_tready |-> m_tvalid, "input stalled with empty output")
  `I2CBM_ASSERT(a_released_high, (m_tvalid && !m_tdata[2]) |-> m_tdata[1], "released SDA not high")
  `I2CBM_ASSERT(a_done_idle, (m_tvalid && m_tdata[4]) |-> !m_tdata[3], "done while still busy")

endmodule

FILE: design/i2cbm_fsm.sv
// Bus sequencer of the I2C bit-level master: advances one tick per accepted item.
module i2cbm_fsm import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [2:0] func,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  input  timing_t    timing,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] poll_count, poll_count_next;
  logic        ack_choice, ack_choice_next;
  logic        scl_lvl, scl_lvl_next;
  logic        sda_lvl, sda_lvl_next;
  logic        sda_en, sda_en_next;
  logic        fail_flag, fail_flag_next;
  logic [7:0]  rx_last, rx_last_next;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 8'd0;
      bit_index  <= 3'd0;
      shift_reg  <= 8'd0;
      poll_count <= 16'd0;
      ack_choice <= 1'b0;
      scl_lvl    <= 1'b1;
      sda_lvl    <= 1'b1;
      sda_en     <= 1'b1;
      fail_flag  <= 1'b0;
      rx_last    <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      poll_count <= poll_count_next;
      ack_choice <= ack_choice_next;
      scl_lvl    <= scl_lvl_next;
      sda_lvl    <= sda_lvl_next;
      sda_en     <= sda_en_next;
      fail_flag  <= fail_flag_next;
      rx_last    <= rx_last_next;
    end
  end

  always_comb begin
    logic poll;
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    poll_count_next = poll_count;
    ack_choice_next = ack_choice;
    scl_lvl_next    = scl_lvl;
    sda_lvl_next    = sda_lvl;
    sda_en_next     = sda_en;
    fail_flag_next  = fail_flag;
    rx_last_next    = rx_last;
    done            = 1'b0;
    poll            = 1'b0;

    if (phase == PH_IDLE) begin
      case (func)
        FUNC_START: begin
          sda_en_next     = 1'b1;
          sda_lvl_next    = 1'b1;
          scl_lvl_next    = 1'b1;
          phase_next      = PH_ST_A;
          tick_count_next = span(timing.start_stop_ticks);
        end
        FUNC_STOP: begin
          sda_en_next     = 1'b1;
          scl_lvl_next    = 1'b0;
          sda_lvl_next    = 1'b0;
          phase_next      = PH_SP_A;
          tick_count_next = span(timing.start_stop_ticks);
        end
        FUNC_SEND: begin
          sda_en_next     = 1'b1;
          scl_lvl_next    = 1'b0;
          shift_reg_next  = tx_byte;
          bit_index_next  = 3'd0;
          sda_lvl_next    = tx_byte[7];
          phase_next      = PH_TX_SET;
          tick_count_next = span(timing.bit_half_ticks);
        end
        FUNC_READ: begin
          sda_en_next     = 1'b0;
          sda_lvl_next    = 1'b1;
          scl_lvl_next    = 1'b0;
          shift_reg_next  = 8'd0;
          bit_index_next  = 3'd0;
          ack_choice_next = send_ack;
          phase_next      = PH_RX_LO;
          tick_count_next = span(timing.bit_half_ticks);
        end
        FUNC_WAIT: begin
          sda_en_next     = 1'b0;
          sda_lvl_next    = 1'b1;
          fail_flag_next  = 1'b0;
          poll_count_next = 16'd0;
          phase_next      = PH_WA_LO;
          tick_count_next = span(timing.bit_half_ticks);
        end
        default: begin
        end
      endcase
    end else if (tick_count != 8'd0) begin
      tick_count_next = tick_count - 8'd1;
    end else begin
      case (phase)
        PH_ST_A: begin
          sda_lvl_next    = 1'b0;
          phase_next      = PH_ST_B;
          tick_count_next = span(timing.start_stop_ticks);
        end
        PH_ST_B: begin
          scl_lvl_next = 1'b0;
          phase_next   = PH_IDLE;
          done         = 1'b1;
        end
        PH_SP_A: begin
          scl_lvl_next    = 1'b1;
          sda_lvl_next    = 1'b1;
          phase_next      = PH_SP_B;
          tick_count_next = span(timing.start_stop_ticks);
        end
        PH_SP_B: begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        PH_TX_SET: begin
          scl_lvl_next    = 1'b1;
          phase_next      = PH_TX_HI;
          tick_count_next = span(timing.bit_half_ticks);
        end
        PH_TX_HI: begin
          scl_lvl_next    = 1'b0;
          phase_next      = PH_TX_LO;
          tick_count_next = span(timing.bit_half_ticks);
        end
        PH_TX_LO: begin
          if (bit_index == LAST_BIT) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            bit_index_next  = bit_index + 3'd1;
            shift_reg_next  = {shift_reg[6:0], 1'b0};
            sda_lvl_next    = shift_reg[6];
            phase_next      = PH_TX_SET;
            tick_count_next = span(timing.bit_half_ticks);
          end
        end
        PH_RX_LO: begin
          scl_lvl_next    = 1'b1;
          shift_reg_next  = {shift_reg[6:0], sda_in};
          phase_next      = PH_RX_HI;
          tick_count_next = span(timing.bit_half_ticks);
        end
        PH_RX_HI: begin
          scl_lvl_next = 1'b0;
          if (bit_index == LAST_BIT) begin
            sda_en_next     = 1'b1;
            sda_lvl_next    = ~ack_choice;
            phase_next      = PH_AK_LO;
            tick_count_next = span(timing.bit_half_ticks);
          end else begin
            bit_index_next  = bit_index + 3'd1;
            phase_next      = PH_RX_LO;
            tick_count_next = span(timing.bit_half_ticks);
          end
        end
        PH_AK_LO: begin
          scl_lvl_next    = 1'b1;
          phase_next      = PH_AK_HI;
          tick_count_next = span(timing.bit_half_ticks);
        end
        PH_AK_HI: begin
          scl_lvl_next = 1'b0;
          rx_last_next = shift_reg;
          phase_next   = PH_IDLE;
          done         = 1'b1;
        end
        PH_WA_LO: begin
          scl_lvl_next    = 1'b1;
          phase_next      = PH_WA_HI;
          tick_count_next = span(timing.bit_half_ticks);
        end
        PH_WA_HI: begin
          phase_next      = PH_WA_POLL;
          tick_count_next = 8'd0;
          poll            = 1'b1;
        end
        PH_WA_POLL: begin
          poll = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (poll) begin
        if (!sda_in) begin
          scl_lvl_next = 1'b0;
          phase_next   = PH_IDLE;
          done         = 1'b1;
        end else if (poll_count >= timing.ack_timeout) begin
          fail_flag_next  = 1'b1;
          sda_en_next     = 1'b1;
          scl_lvl_next    = 1'b0;
          sda_lvl_next    = 1'b0;
          phase_next      = PH_SP_A;
          tick_count_next = span(timing.start_stop_ticks);
        end else begin
          poll_count_next = poll_count + 16'd1;
        end
      end
    end
  end

  always_comb begin
    result.scl_out    = scl_lvl_next;
    result.sda_out    = sda_en_next ? sda_lvl_next : 1'b1;
    result.sda_drive  = sda_en_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = done;
    result.rx_byte    = rx_last_next;
    result.ack_failed = fail_flag_next;
  end

endmodule
